// ===== rtl/bilinear_glyph_scaler_unit_assert.svh =====
// assertion macros for the bilinear glyph scaler
// expects clk and arst_n in the scope of the module that uses them
`ifndef BILINEAR_GLYPH_SCALER_UNIT_ASSERT_SVH
`define BILINEAR_GLYPH_SCALER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// property checked on every rising edge outside reset
`define BGS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
	else $error("bilinear glyph scaler assertion failed");

// condition that must never be seen outside reset
`define BGS_ASSERT_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
	else $error("bilinear glyph scaler forbidden condition seen");

`else

`define BGS_ASSERT(lbl, prop)
`define BGS_ASSERT_NEVER(lbl, expr)

`endif

`endif

// ===== rtl/bgs_pkg.sv =====
// shared types and constants of the bilinear glyph scaler
// no dependencies
package bgs_pkg;

	// item kinds on the input channel
	typedef enum logic {
		CMD_LOAD   = 1'b0,
		CMD_SAMPLE = 1'b1
	} cmd_t;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_X_STEP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_Y_STEP = 2'd1;

	// 1.16 fixed point steps
	localparam int unsigned FRAC_W = 16;
	localparam int unsigned STEP_W = 17;
	localparam logic [STEP_W-1:0] STEP_RESET = 17'h10000;

	// byte fields and source positions (8-bit coordinate times 17-bit step)
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned POS_W  = BYTE_W + STEP_W;
	localparam int unsigned INT_W  = POS_W - FRAC_W;

	// signed blend products: 9-bit difference times 17-bit fraction
	localparam int unsigned PROD_W = (BYTE_W + 1) + (FRAC_W + 1);

endpackage

// ===== rtl/bilinear_glyph_scaler_unit.sv =====
// A sample transfer gives its pixel on out_valid after the stage 1 to 4 and output registers; a load gives nothing.
// Throughput: one item per cycle unless out_stall holds the pipeline; each glyph row pair is read at once from two
// dual-read memories (even rows, odd rows), so the four neighbors never contend.
// Reset clears the pipeline valid bits and sets both steps to 1.0; the glyph store is
// not cleared and holds garbage until loaded.
`include "bilinear_glyph_scaler_unit_assert.svh"

module bilinear_glyph_scaler_unit #(
	parameter int unsigned SRC_W = 9,
	parameter int unsigned SRC_H = 19
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write port
	input  logic                                cfg_we,
	input  logic [bgs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bgs_pkg::STEP_W-1:0]          cfg_data,
	// input channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  bgs_pkg::cmd_t                       command,
	input  logic [7:0]                          load_index,
	input  logic [7:0]                          load_value,
	input  logic [7:0]                          dest_x,
	input  logic [7:0]                          dest_y,
	// output channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [7:0]                          pixel
);

	import bgs_pkg::*;

	// geometry derived from the glyph size
	localparam int unsigned DEPTH    = SRC_W * SRC_H;
	localparam int unsigned EV_ROWS  = (SRC_H + 1) / 2;
	localparam int unsigned OD_ROWS  = (SRC_H / 2 > 0) ? SRC_H / 2 : 1;
	localparam int unsigned EV_DEPTH = EV_ROWS * SRC_W;
	localparam int unsigned OD_DEPTH = OD_ROWS * SRC_W;
	localparam int unsigned EV_AW    = (EV_DEPTH > 1) ? $clog2(EV_DEPTH) : 1;
	localparam int unsigned OD_AW    = (OD_DEPTH > 1) ? $clog2(OD_DEPTH) : 1;
	localparam int unsigned CW       = (SRC_W > 1) ? $clog2(SRC_W) : 1;
	localparam int unsigned RW       = (SRC_H > 1) ? $clog2(SRC_H) : 1;
	localparam int unsigned AXW      = (DEPTH > 256) ? $clog2(DEPTH + 1) : 9;
	localparam logic [STEP_W-1:0] RECIP = STEP_W'((1 << FRAC_W) / SRC_W);

	// step registers
	logic [STEP_W-1:0] x_step_q, y_step_q;

	// pipeline enables, collapsing bubbles
	logic adv_s1, adv_s2, adv_s3, adv_s4, adv_out;
	logic vld_s1, vld_s2, vld_s3, vld_s4, out_valid_q;

	// stage 1 payload
	cmd_t             cmd_s1;
	logic             load_ok_s1;
	logic [7:0]       idx_s1, val_s1, q0_s1;
	logic [POS_W-1:0] sx_s1, sy_s1;

	// stage 1 logic
	logic [INT_W-1:0] xa_raw, xb_raw, ya_raw, yb_raw;
	logic [CW-1:0]    xa, xb;
	logic [RW-1:0]    ya, yb, ev_row, od_row;
	logic             ya_odd, same_row;
	logic [AXW-1:0]   ev_base, od_base;
	logic [EV_AW-1:0] ev_addr_a, ev_addr_b, ld_ev_addr;
	logic [OD_AW-1:0] od_addr_a, od_addr_b, ld_od_addr;
	logic [7:0]       ld_r0, ld_col;
	logic             ld_row_odd;
	logic [8:0]       ld_sum;
	logic             rd_en, wr_ev, wr_od;

	// glyph store split by row parity
	logic [7:0] mem_ev [EV_DEPTH];
	logic [7:0] mem_od [OD_DEPTH];

	// stage 2 payload
	logic [7:0]          ev_a_s2, ev_b_s2, od_a_s2, od_b_s2;
	logic [FRAC_W-1:0]   fx_s2, fy_s2;
	logic                ya_odd_s2, same_row_s2;

	// stage 2 logic
	logic [7:0]               pa, pb, pc, pd;
	logic signed [8:0]        dh_u, dh_l;
	logic signed [PROD_W-1:0] pu, pl;

	// stage 3 payload
	logic [7:0]               pa_s3, pc_s3;
	logic signed [PROD_W-1:0] pu_s3, pl_s3;
	logic [FRAC_W-1:0]        fy_s3;

	// stage 3 logic
	logic signed [9:0]        up_w, lo_w;
	logic [7:0]               up, lo;
	logic signed [8:0]        dv;
	logic signed [PROD_W-1:0] pv;

	// stage 4 payload
	logic [7:0]               up_s4;
	logic signed [PROD_W-1:0] pv_s4;

	// output register
	logic signed [9:0] pix_w;
	logic [7:0]        pixel_q;

	// configuration writes, other indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_step_q <= STEP_RESET;
			y_step_q <= STEP_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_X_STEP: x_step_q <= cfg_data;
				REG_Y_STEP: y_step_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage enables
	assign adv_out  = !out_valid_q || !out_stall;
	assign adv_s4   = !vld_s4 || adv_out;
	assign adv_s3   = !vld_s3 || adv_s4;
	assign adv_s2   = !vld_s2 || adv_s3;
	assign adv_s1   = !vld_s1 || adv_s2;
	assign in_stall = !adv_s1;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			vld_s4      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv_s1)  vld_s1      <= in_valid;
			if (adv_s2)  vld_s2      <= vld_s1 && (cmd_s1 == CMD_SAMPLE);
			if (adv_s3)  vld_s3      <= vld_s2;
			if (adv_s4)  vld_s4      <= vld_s3;
			if (adv_out) out_valid_q <= vld_s4;
		end
	end

	// stage 1 capture: source positions and approximate load row
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			cmd_s1     <= command;
			idx_s1     <= load_index;
			val_s1     <= load_value;
			load_ok_s1 <= AXW'(load_index) < AXW'(DEPTH);
			q0_s1      <= 8'(((POS_W'(load_index) * POS_W'(RECIP)) >> FRAC_W));
			sx_s1      <= POS_W'(dest_x) * POS_W'(x_step_q);
			sy_s1      <= POS_W'(dest_y) * POS_W'(y_step_q);
		end
	end

	// neighbor coordinates clamped to the glyph edge
	always_comb begin
		xa_raw = sx_s1[POS_W-1:FRAC_W];
		ya_raw = sy_s1[POS_W-1:FRAC_W];
		xb_raw = xa_raw + INT_W'(1);
		yb_raw = ya_raw + INT_W'(1);
		xa = (xa_raw >= INT_W'(SRC_W)) ? CW'(SRC_W - 1) : xa_raw[CW-1:0];
		xb = (xb_raw >= INT_W'(SRC_W)) ? CW'(SRC_W - 1) : xb_raw[CW-1:0];
		ya = (ya_raw >= INT_W'(SRC_H)) ? RW'(SRC_H - 1) : ya_raw[RW-1:0];
		yb = (yb_raw >= INT_W'(SRC_H)) ? RW'(SRC_H - 1) : yb_raw[RW-1:0];
	end

	// row pair to bank addresses; an unused bank reads from its row 0
	always_comb begin
		ya_odd   = ya[0];
		same_row = (ya == yb);
		ev_row   = ya_odd ? yb : ya;
		od_row   = ya_odd ? ya : yb;
		if (same_row && ya_odd) ev_row = '0;
		if (same_row && !ya_odd) od_row = '0;
		ev_base   = AXW'(ev_row >> 1) * AXW'(SRC_W);
		od_base   = AXW'(od_row >> 1) * AXW'(SRC_W);
		ev_addr_a = EV_AW'(ev_base + AXW'(xa));
		ev_addr_b = EV_AW'(ev_base + AXW'(xb));
		od_addr_a = OD_AW'(od_base + AXW'(xa));
		od_addr_b = OD_AW'(od_base + AXW'(xb));
	end

	// load index split into row parity and column, bank address from the index
	always_comb begin
		ld_r0      = idx_s1 - 8'(q0_s1 * 8'(SRC_W));
		ld_col     = (ld_r0 >= 8'(SRC_W)) ? ld_r0 - 8'(SRC_W) : ld_r0;
		ld_row_odd = (ld_r0 >= 8'(SRC_W)) ? !q0_s1[0] : q0_s1[0];
		ld_sum     = 9'(idx_s1) + 9'(ld_col);
		ld_ev_addr = EV_AW'(ld_sum >> 1);
		ld_od_addr = OD_AW'((ld_sum - 9'(SRC_W)) >> 1);
	end

	// store accesses happen as an item leaves stage 1, so they stay in order
	assign rd_en = adv_s2 && vld_s1 && (cmd_s1 == CMD_SAMPLE);
	assign wr_ev = adv_s2 && vld_s1 && (cmd_s1 == CMD_LOAD) && load_ok_s1 && !ld_row_odd;
	assign wr_od = adv_s2 && vld_s1 && (cmd_s1 == CMD_LOAD) && load_ok_s1 && ld_row_odd;

	// glyph store, one write and two registered reads per bank
	always_ff @(posedge clk) begin
		if (wr_ev) mem_ev[ld_ev_addr] <= val_s1;
		if (wr_od) mem_od[ld_od_addr] <= val_s1;
		if (rd_en) begin
			ev_a_s2 <= mem_ev[ev_addr_a];
			ev_b_s2 <= mem_ev[ev_addr_b];
			od_a_s2 <= mem_od[od_addr_a];
			od_b_s2 <= mem_od[od_addr_b];
		end
	end

	// stage 2 capture of fractions and row routing
	always_ff @(posedge clk) begin
		if (adv_s2) begin
			fx_s2       <= sx_s1[FRAC_W-1:0];
			fy_s2       <= sy_s1[FRAC_W-1:0];
			ya_odd_s2   <= ya_odd;
			same_row_s2 <= same_row;
		end
	end

	// route banks to the four neighbors and start the horizontal blends
	always_comb begin
		pa = ya_odd_s2 ? od_a_s2 : ev_a_s2;
		pb = ya_odd_s2 ? od_b_s2 : ev_b_s2;
		pc = same_row_s2 ? pa : (ya_odd_s2 ? ev_a_s2 : od_a_s2);
		pd = same_row_s2 ? pb : (ya_odd_s2 ? ev_b_s2 : od_b_s2);
		dh_u = signed'({1'b0, pb}) - signed'({1'b0, pa});
		dh_l = signed'({1'b0, pd}) - signed'({1'b0, pc});
		pu = PROD_W'(dh_u * signed'({1'b0, fx_s2}));
		pl = PROD_W'(dh_l * signed'({1'b0, fx_s2}));
	end

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			pa_s3 <= pa;
			pc_s3 <= pc;
			pu_s3 <= pu;
			pl_s3 <= pl;
			fy_s3 <= fy_s2;
		end
	end

	// finish horizontal blends, start the vertical blend
	always_comb begin
		up_w = signed'({2'b00, pa_s3}) + pu_s3[PROD_W-1:FRAC_W];
		lo_w = signed'({2'b00, pc_s3}) + pl_s3[PROD_W-1:FRAC_W];
		up   = up_w[7:0];
		lo   = lo_w[7:0];
		dv   = signed'({1'b0, lo}) - signed'({1'b0, up});
		pv   = PROD_W'(dv * signed'({1'b0, fy_s3}));
	end

	always_ff @(posedge clk) begin
		if (adv_s4) begin
			up_s4 <= up;
			pv_s4 <= pv;
		end
	end

	// finish the vertical blend into the output register
	assign pix_w = signed'({2'b00, up_s4}) + pv_s4[PROD_W-1:FRAC_W];

	always_ff @(posedge clk) begin
		if (adv_out) pixel_q <= pix_w[7:0];
	end

	assign out_valid = out_valid_q;
	assign pixel     = pixel_q;

	// checks on pipeline flow and coordinate clamping
	`BGS_ASSERT(a_accept_fills_s1, in_valid && !in_stall |=> vld_s1)
	`BGS_ASSERT(a_s3_holds, vld_s3 && !adv_s4 |=> vld_s3 && $stable(pu_s3))
	`BGS_ASSERT(a_s4_holds, vld_s4 && out_valid && out_stall |=> vld_s4 && $stable(up_s4))
	`BGS_ASSERT_NEVER(a_clamp_range, vld_s1 && (cmd_s1 == CMD_SAMPLE) && (xb < xa || yb < ya))

endmodule
